### rtl/core/sur_pkg.sv
// Shared types and constants of the segmented upload receiver.
package sur_pkg;

    localparam int NUM_W = 33;
    localparam int DEN_W = 16;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_OK   = 2'd1;
    localparam logic [1:0] KIND_FAIL = 2'd2;

    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_ACCEPT   = 3'd1;
    localparam logic [2:0] EV_CANCEL   = 3'd2;
    localparam logic [2:0] EV_ERROR    = 3'd3;
    localparam logic [2:0] EV_COMPLETE = 3'd4;
    localparam logic [2:0] EV_TIMEOUT  = 3'd5;
    localparam logic [2:0] EV_APPLYING = 3'd6;

    localparam logic [3:0] REP_NONE = 4'd0;
    localparam logic [3:0] REP_ONCE = 4'd1;
    localparam logic [3:0] REP_MID  = 4'd2;
    localparam logic [3:0] REP_LAST = 4'd10;

    localparam logic [16:0] LIMIT_SLACK  = 17'd50;
    localparam logic [31:0] CANCEL_INDEX = 32'hFFFF_FFFF;

    localparam logic [15:0] TIMEOUT_RST   = 16'd5000;
    localparam logic [31:0] MAX_TOTAL_RST = 32'd50000000;

    localparam logic REG_TIMEOUT   = 1'b0;
    localparam logic REG_MAX_TOTAL = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_DIV,
        S_INDEX,
        S_RMW,
        S_CHK_RD,
        S_CHK_EV,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] rep;
        logic [2:0] ev;
    } t_result;

endpackage

### rtl/core/sur_div.sv
// Restoring divider that produces one quotient bit per cycle.
module sur_div
    import sur_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(NUM_W);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [DEN_W-1:0] r_rem, n_rem;
    logic [DEN_W-1:0] r_den, n_den;
    logic [NUM_W-1:0] r_quo, n_quo;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    always_comb begin
        trial  = {r_rem, r_quo[NUM_W-1]};
        diff   = trial - {1'b0, r_den};
        ge     = (trial >= {1'b0, r_den});
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_den  = r_den;
        n_quo  = r_quo;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_num;
            n_den  = i_den;
        end else if (r_busy) begin
            n_rem = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            n_quo = {r_quo[NUM_W-2:0], ge};
            n_cnt = r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(NUM_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_den <= n_den;
        r_quo <= n_quo;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

### rtl/core/segmented_upload_receiver.sv
// Top level of the segmented upload receiver: sequencer, segment bitmap and registers.
//
// Usage: segment packets and time ticks enter on the s_axis channel, one beat each,
// and every input beat yields exactly one result beat on the m_axis channel.
// Two registers (timeout_ms, max_total_bytes) are to be written over the APB port only
// while the block is idle; the block itself does not enforce this. pready is always high.
// The block works on one beat at a time and holds s_axis_tready low until that
// beat's result is loaded into the output register. A segment of a known session
// that asks for an ack checks bitmap words one at a time: one or two words for a
// middle segment, up to MAX_SEGMENTS/32 words for the last segment. The first
// segment of a session also runs the bit-serial segment count division.
// Every session reset, and the reset of the block itself, is followed by a clearing
// pass over all MAX_SEGMENTS/32 bitmap words, with s_axis_tready low.
// The result waits in the output register while m_axis_tready is low; the next
// beat is already taken meanwhile, and its result waits until the register frees.
module segmented_upload_receiver
    import sur_pkg::*;
#(
    parameter int MAX_SEGMENTS = 4096,
    parameter int WINDOW       = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // frame_short, want_ack, block_index, upload_bytes, seg_bytes, payload_length,
    // time_now
    input  logic [135:0] s_axis_tdata,
    // req_type
    input  logic         s_axis_tuser,
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // reply_repeat, event_res, bytes_received
    output logic [39:0]  m_axis_tdata,
    // reply_kind
    output logic [1:0]   m_axis_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int WORDS     = (MAX_SEGMENTS + 31) / 32;
    localparam int AW        = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int BIW       = AW + 5;
    localparam int CW        = $clog2(MAX_SEGMENTS + 1);
    localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);

    t_state        r_state, n_state;
    logic [AW-1:0] r_word, n_word;
    logic          r_clr_after, n_clr_after;
    logic [CW-1:0] r_seg_count, n_seg_count;
    logic [16:0]   r_seg_limit, n_seg_limit;
    logic          r_active, n_active;
    logic          r_map_ready, n_map_ready;
    logic [31:0]   r_byte_total, n_byte_total;
    logic [31:0]   r_last_seen, n_last_seen;
    logic          r_applying, n_applying;
    logic          r_m_valid, n_m_valid;
    logic [15:0]   r_timeout;
    logic [31:0]   r_max_total;

    logic          r_in_req, n_in_req;
    logic          r_in_short, n_in_short;
    logic          r_in_ack, n_in_ack;
    logic [31:0]   r_in_idx, n_in_idx;
    logic [31:0]   r_in_total, n_in_total;
    logic [15:0]   r_in_blen, n_in_blen;
    logic          r_in_last, n_in_last;
    logic [15:0]   r_in_plen, n_in_plen;
    logic [31:0]   r_in_now, n_in_now;
    t_result       r_res, n_res;
    t_result       r_m_res, n_m_res;
    logic [31:0]   r_m_bytes, n_m_bytes;
    logic [AW-1:0] r_lo_word, n_lo_word;
    logic [AW-1:0] r_hi_word, n_hi_word;
    logic [4:0]    r_lo_bit, n_lo_bit;
    logic [4:0]    r_hi_bit, n_hi_bit;

    logic [31:0]   mem [WORDS];
    logic [31:0]   r_rdata;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [31:0]   mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;

    logic             div_start;
    logic             div_done;
    logic [NUM_W-1:0] div_quo;
    logic [NUM_W-1:0] div_num;

    logic          do_clear;
    logic          do_fail;
    logic [AW-1:0] idx_word;
    logic [4:0]    idx_bit;
    logic [31:0]   lo_idx;
    logic [31:0]   hi_idx;
    logic [4:0]    mask_lo;
    logic [4:0]    mask_hi;
    logic [31:0]   chk_mask;
    logic          timed_out;

    assign div_num   = {1'b0, r_in_total} + NUM_W'(r_in_blen) - NUM_W'(1);
    assign idx_word  = r_in_idx[BIW-1:5];
    assign idx_bit   = r_in_idx[4:0];
    assign mask_lo   = (r_word == r_lo_word) ? r_lo_bit : 5'd0;
    assign mask_hi   = (r_word == r_hi_word) ? r_hi_bit : 5'd31;
    assign chk_mask  = ({32{1'b1}} << mask_lo) & ({32{1'b1}} >> (5'd31 - mask_hi));
    assign timed_out = ({1'b0, r_in_now} > ({1'b0, r_last_seen} + 33'(r_timeout)));
    assign lo_idx    = r_in_last ? 32'd0 :
                       ((r_in_idx >= 32'(WINDOW)) ? (r_in_idx - 32'(WINDOW)) : 32'd0);
    assign hi_idx    = r_in_last ? (32'(r_seg_count) - 32'd1) : r_in_idx;

    sur_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_in_blen),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_comb begin
        n_state      = r_state;
        n_word       = r_word;
        n_clr_after  = r_clr_after;
        n_seg_count  = r_seg_count;
        n_seg_limit  = r_seg_limit;
        n_active     = r_active;
        n_map_ready  = r_map_ready;
        n_byte_total = r_byte_total;
        n_last_seen  = r_last_seen;
        n_applying   = r_applying;
        n_m_valid    = r_m_valid;
        n_in_req     = r_in_req;
        n_in_short   = r_in_short;
        n_in_ack     = r_in_ack;
        n_in_idx     = r_in_idx;
        n_in_total   = r_in_total;
        n_in_blen    = r_in_blen;
        n_in_last    = r_in_last;
        n_in_plen    = r_in_plen;
        n_in_now     = r_in_now;
        n_res        = r_res;
        n_m_res      = r_m_res;
        n_m_bytes    = r_m_bytes;
        n_lo_word    = r_lo_word;
        n_hi_word    = r_hi_word;
        n_lo_bit     = r_lo_bit;
        n_hi_bit     = r_hi_bit;
        mem_we       = 1'b0;
        mem_waddr    = r_word;
        mem_wdata    = '0;
        mem_re       = 1'b0;
        mem_raddr    = r_word;
        div_start    = 1'b0;
        do_clear     = 1'b0;
        do_fail      = 1'b0;
        s_axis_tready = 1'b0;

        if (r_m_valid && m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                if (r_word == LAST_WORD) begin
                    n_word  = '0;
                    n_state = S_IDLE;
                end else begin
                    n_word = r_word + AW'(1);
                end
            end
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_in_req   = s_axis_tuser;
                    n_in_short = s_axis_tdata[0];
                    n_in_ack   = s_axis_tdata[1];
                    n_in_idx   = s_axis_tdata[33:2];
                    n_in_total = s_axis_tdata[65:34];
                    n_in_blen  = s_axis_tdata[81:66];
                    n_in_plen  = s_axis_tdata[97:82];
                    n_in_now   = s_axis_tdata[129:98];
                    n_in_last  = s_axis_tlast;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (r_in_req) begin
                    n_state = S_EMIT;
                    if (r_active && !r_applying && timed_out) begin
                        n_last_seen = '0;
                        do_clear    = 1'b1;
                        n_res       = '{kind: KIND_NONE, rep: REP_NONE, ev: EV_TIMEOUT};
                    end else begin
                        n_res = '{kind: KIND_NONE, rep: REP_NONE, ev: EV_NONE};
                    end
                end else if (r_in_short) begin
                    do_fail = 1'b1;
                end else begin
                    n_last_seen = r_in_now;
                    if (r_in_idx == CANCEL_INDEX || r_in_total == 32'd0) begin
                        do_clear = 1'b1;
                        n_res    = '{kind: KIND_OK, rep: REP_ONCE, ev: EV_CANCEL};
                        n_state  = S_EMIT;
                    end else if (r_in_blen == 16'd0 || r_in_total > r_max_total) begin
                        do_fail = 1'b1;
                    end else begin
                        n_active = 1'b1;
                        if (!r_map_ready) begin
                            div_start = 1'b1;
                            n_state   = S_DIV;
                        end else begin
                            n_state = S_INDEX;
                        end
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    if (div_quo > NUM_W'(MAX_SEGMENTS)) begin
                        do_fail = 1'b1;
                    end else begin
                        n_seg_count = div_quo[CW-1:0];
                        n_seg_limit = {1'b0, r_in_blen} + LIMIT_SLACK;
                        n_map_ready = 1'b1;
                        n_state     = S_INDEX;
                    end
                end
            end
            S_INDEX: begin
                if (r_in_idx >= 32'(r_seg_count)) begin
                    do_fail = 1'b1;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = idx_word;
                    n_state   = S_RMW;
                end
            end
            S_RMW: begin
                if (!r_rdata[idx_bit]) begin
                    mem_we       = 1'b1;
                    mem_waddr    = idx_word;
                    mem_wdata    = r_rdata | (32'd1 << idx_bit);
                    n_byte_total = r_byte_total + 32'(r_in_plen);
                end
                if ({1'b0, r_in_plen} > r_seg_limit) begin
                    do_fail = 1'b1;
                end else if (!r_in_ack) begin
                    n_res   = '{kind: KIND_NONE, rep: REP_NONE, ev: EV_ACCEPT};
                    n_state = S_EMIT;
                end else begin
                    n_lo_word = lo_idx[BIW-1:5];
                    n_lo_bit  = lo_idx[4:0];
                    n_hi_word = hi_idx[BIW-1:5];
                    n_hi_bit  = hi_idx[4:0];
                    n_word    = lo_idx[BIW-1:5];
                    n_state   = S_CHK_RD;
                end
            end
            S_CHK_RD: begin
                mem_re  = 1'b1;
                n_state = S_CHK_EV;
            end
            S_CHK_EV: begin
                if ((r_rdata & chk_mask) != chk_mask) begin
                    n_res   = '{kind: KIND_FAIL, rep: (r_in_last ? REP_LAST : REP_MID),
                                ev: EV_ACCEPT};
                    n_word  = '0;
                    n_state = S_EMIT;
                end else if (r_word == r_hi_word) begin
                    n_word  = '0;
                    n_state = S_EMIT;
                    if (!r_in_last) begin
                        n_res = '{kind: KIND_OK, rep: REP_MID, ev: EV_ACCEPT};
                    end else if (r_applying) begin
                        n_res = '{kind: KIND_OK, rep: REP_LAST, ev: EV_APPLYING};
                    end else begin
                        n_applying = 1'b1;
                        n_res      = '{kind: KIND_OK, rep: REP_LAST, ev: EV_COMPLETE};
                    end
                end else begin
                    n_word  = r_word + AW'(1);
                    n_state = S_CHK_RD;
                end
            end
            S_EMIT: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_m_valid = 1'b1;
                    n_m_res   = r_res;
                    n_m_bytes = r_byte_total;
                    n_word    = '0;
                    if (r_clr_after) begin
                        n_clr_after = 1'b0;
                        n_state     = S_CLEAR;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (do_fail) begin
            n_res   = '{kind: KIND_FAIL, rep: REP_ONCE, ev: EV_ERROR};
            n_state = S_EMIT;
        end
        if (do_fail || do_clear) begin
            n_seg_count  = '0;
            n_seg_limit  = '0;
            n_active     = 1'b0;
            n_map_ready  = 1'b0;
            n_byte_total = '0;
            n_applying   = 1'b0;
            n_clr_after  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_word       <= '0;
            r_clr_after  <= 1'b0;
            r_seg_count  <= '0;
            r_seg_limit  <= '0;
            r_active     <= 1'b0;
            r_map_ready  <= 1'b0;
            r_byte_total <= '0;
            r_last_seen  <= '0;
            r_applying   <= 1'b0;
            r_m_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_word       <= n_word;
            r_clr_after  <= n_clr_after;
            r_seg_count  <= n_seg_count;
            r_seg_limit  <= n_seg_limit;
            r_active     <= n_active;
            r_map_ready  <= n_map_ready;
            r_byte_total <= n_byte_total;
            r_last_seen  <= n_last_seen;
            r_applying   <= n_applying;
            r_m_valid    <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_req   <= n_in_req;
        r_in_short <= n_in_short;
        r_in_ack   <= n_in_ack;
        r_in_idx   <= n_in_idx;
        r_in_total <= n_in_total;
        r_in_blen  <= n_in_blen;
        r_in_last  <= n_in_last;
        r_in_plen  <= n_in_plen;
        r_in_now   <= n_in_now;
        r_res      <= n_res;
        r_m_res    <= n_m_res;
        r_m_bytes  <= n_m_bytes;
        r_lo_word  <= n_lo_word;
        r_hi_word  <= n_hi_word;
        r_lo_bit   <= n_lo_bit;
        r_hi_bit   <= n_hi_bit;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout   <= TIMEOUT_RST;
            r_max_total <= MAX_TOTAL_RST;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[2])
                REG_TIMEOUT:   r_timeout   <= pwdata[15:0];
                REG_MAX_TOTAL: r_max_total <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_TIMEOUT:   prdata = {16'd0, r_timeout};
            REG_MAX_TOTAL: prdata = r_max_total;
            default:       prdata = '0;
        endcase
    end

    assign pready        = 1'b1;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_res.kind;
    assign m_axis_tdata  = {1'b0, r_m_bytes, r_m_res.ev, r_m_res.rep};

    a_map_needs_session: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_map_ready |-> (r_active && r_seg_count != '0))
        else $error("segment map is ready without an open session");

    a_applying_needs_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_applying |-> r_map_ready)
        else $error("applying is set without a segment map");

    a_limit_has_slack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_map_ready |-> (r_seg_limit > LIMIT_SLACK))
        else $error("segment size limit is below its slack");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_state == S_DISPATCH && !s_axis_tready))
        else $error("accepted beat did not start processing");

endmodule

### verif/tb_top.sv
// Self-checking testbench for the segmented upload receiver, checked against a predictor.
module tb_top
    import sur_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SEG_DEPTH      = 4096;
    localparam int CHECK_WINDOW   = 8;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 400;

    typedef struct packed {
        bit          tick;
        bit          frame_short;
        bit          want_ack;
        logic [31:0] block_index;
        logic [31:0] upload_bytes;
        logic [15:0] seg_bytes;
        bit          is_last;
        logic [15:0] payload_length;
        logic [31:0] time_now;
    } upload_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  rep;
        logic [2:0]  ev;
        logic [31:0] byte_count;
    } reply_t;

    class upload_tracker;
        reply_t      pending_replies[$];
        bit          seg_seen[SEG_DEPTH];
        int unsigned seg_count;
        logic [16:0] seg_limit;
        bit          active;
        bit          map_ready;
        bit          applying;
        logic [31:0] byte_total;
        logic [31:0] last_seen;
        logic [15:0] timeout_limit;
        logic [31:0] max_total;
        int unsigned mismatches;

        function new();
            timeout_limit = TIMEOUT_RST;
            max_total     = MAX_TOTAL_RST;
            last_seen     = '0;
            mismatches    = 0;
            clear_session();
        endfunction

        function void clear_session();
            foreach (seg_seen[i]) seg_seen[i] = 1'b0;
            seg_count  = 0;
            seg_limit  = '0;
            active     = 1'b0;
            map_ready  = 1'b0;
            byte_total = '0;
            applying   = 1'b0;
        endfunction

        function void set_register(logic [2:0] addr, logic [31:0] value);
            if (addr[2] == REG_TIMEOUT) begin
                timeout_limit = value[15:0];
            end else begin
                max_total = value;
            end
        endfunction

        function void flag_error(string msg);
            mismatches++;
            if (mismatches <= 10) begin
                $display("[%0t] MISMATCH: %s", $realtime, msg);
            end
        endfunction

        function reply_t make_reply(logic [1:0] kind, logic [3:0] rep, logic [2:0] ev);
            reply_t r;
            r.kind       = kind;
            r.rep        = rep;
            r.ev         = ev;
            r.byte_count = byte_total;
            return r;
        endfunction

        function reply_t fail_reset();
            clear_session();
            return make_reply(KIND_FAIL, REP_ONCE, EV_ERROR);
        endfunction

        function bit window_complete(logic [31:0] idx, bit last);
            if (last) begin
                for (int unsigned i = 0; i < seg_count && i < SEG_DEPTH; i++) begin
                    if (!seg_seen[i]) return 1'b0;
                end
                return 1'b1;
            end
            for (int unsigned i = 0; i <= CHECK_WINDOW && i <= idx; i++) begin
                if (!seg_seen[idx - i]) return 1'b0;
            end
            return 1'b1;
        endfunction

        function reply_t predict_reply(upload_item_t it);
            longint unsigned span;
            logic [3:0]      rep;
            if (it.tick) begin
                if (active && !applying &&
                    {1'b0, it.time_now} > {1'b0, last_seen} + timeout_limit) begin
                    last_seen = '0;
                    clear_session();
                    return make_reply(KIND_NONE, REP_NONE, EV_TIMEOUT);
                end
                return make_reply(KIND_NONE, REP_NONE, EV_NONE);
            end
            if (it.frame_short) return fail_reset();
            last_seen = it.time_now;
            if (it.block_index == CANCEL_INDEX || it.upload_bytes == 0) begin
                clear_session();
                return make_reply(KIND_OK, REP_ONCE, EV_CANCEL);
            end
            if (it.seg_bytes == 0 || it.upload_bytes > max_total) return fail_reset();
            active = 1'b1;
            if (!map_ready) begin
                span = it.upload_bytes;
                span = (span + it.seg_bytes - 1) / it.seg_bytes;
                if (span > SEG_DEPTH) return fail_reset();
                seg_count = 32'(span);
                seg_limit = {1'b0, it.seg_bytes} + LIMIT_SLACK;
                map_ready = 1'b1;
            end
            if (it.block_index >= seg_count || it.block_index >= SEG_DEPTH) return fail_reset();
            if (!seg_seen[it.block_index]) begin
                seg_seen[it.block_index] = 1'b1;
                byte_total += it.payload_length;
            end
            if (it.payload_length > seg_limit) return fail_reset();
            if (!it.want_ack) return make_reply(KIND_NONE, REP_NONE, EV_ACCEPT);
            rep = it.is_last ? REP_LAST : REP_MID;
            if (!window_complete(it.block_index, it.is_last)) begin
                return make_reply(KIND_FAIL, rep, EV_ACCEPT);
            end
            if (!it.is_last) return make_reply(KIND_OK, rep, EV_ACCEPT);
            if (applying) return make_reply(KIND_OK, rep, EV_APPLYING);
            applying = 1'b1;
            return make_reply(KIND_OK, rep, EV_COMPLETE);
        endfunction

        function void note_input(upload_item_t it);
            pending_replies.push_back(predict_reply(it));
        endfunction

        function void check_result(reply_t got);
            reply_t exp;
            if (pending_replies.size() == 0) begin
                flag_error($sformatf("unexpected result kind=%0d rep=%0d ev=%0d bytes=%0d",
                                     got.kind, got.rep, got.ev, got.byte_count));
                return;
            end
            exp = pending_replies.pop_front();
            if (got.kind !== exp.kind || got.rep !== exp.rep || got.ev !== exp.ev ||
                got.byte_count !== exp.byte_count) begin
                flag_error($sformatf({"expected kind=%0d rep=%0d ev=%0d bytes=%0d, ",
                                      "got kind=%0d rep=%0d ev=%0d bytes=%0d"},
                                     exp.kind, exp.rep, exp.ev, exp.byte_count,
                                     got.kind, got.rep, got.ev, got.byte_count));
            end
        endfunction
    endclass

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata = '0;
    logic         s_axis_tuser = 1'b0;
    logic         s_axis_tlast = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [39:0]  m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    upload_tracker tracker;
    bit            gaps_on = 1'b1;
    bit            stalls_on = 1'b1;
    int            ready_hold = 0;
    int            ready_pick;
    int            stuck_cycles = 0;
    int unsigned   items_sent = 0;
    logic [31:0]   now_ms = 32'd1000;
    reply_t        seen_reply;

    segmented_upload_receiver #(
        .MAX_SEGMENTS(SEG_DEPTH),
        .WINDOW      (CHECK_WINDOW)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!stalls_on) begin
            m_axis_tready <= 1'b1;
        end else if (ready_hold > 0) begin
            ready_hold--;
        end else begin
            ready_pick = $urandom_range(0, 99);
            if (ready_pick < 60) begin
                m_axis_tready <= 1'b1;
                ready_hold = $urandom_range(0, 8);
            end else if (ready_pick < 95) begin
                m_axis_tready <= 1'b0;
                ready_hold = $urandom_range(0, 3);
            end else begin
                m_axis_tready <= 1'b0;
                ready_hold = $urandom_range(10, 60);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen_reply.kind       = m_axis_tuser;
            seen_reply.rep        = m_axis_tdata[3:0];
            seen_reply.ev         = m_axis_tdata[6:4];
            seen_reply.byte_count = m_axis_tdata[38:7];
            tracker.check_result(seen_reply);
        end
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
            if (stuck_cycles >= WATCHDOG_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic upload_item_t random_item();
        upload_item_t it;
        it.tick           = $urandom_range(0, 1);
        it.frame_short    = $urandom_range(0, 1);
        it.want_ack       = $urandom_range(0, 1);
        it.block_index    = $urandom();
        it.upload_bytes   = $urandom();
        it.seg_bytes      = $urandom_range(0, 65535);
        it.is_last        = $urandom_range(0, 1);
        it.payload_length = $urandom_range(0, 65535);
        it.time_now       = $urandom();
        return it;
    endfunction

    function automatic upload_item_t seg_item(logic [31:0] idx, logic [31:0] total,
                                              logic [15:0] blen, logic [15:0] plen,
                                              bit ack, bit last, logic [31:0] t);
        upload_item_t it;
        it                = random_item();
        it.tick           = 1'b0;
        it.frame_short    = 1'b0;
        it.want_ack       = ack;
        it.block_index    = idx;
        it.upload_bytes   = total;
        it.seg_bytes      = blen;
        it.is_last        = last;
        it.payload_length = plen;
        it.time_now       = t;
        return it;
    endfunction

    function automatic upload_item_t tick_item(logic [31:0] t);
        upload_item_t it;
        it          = random_item();
        it.tick     = 1'b1;
        it.time_now = t;
        return it;
    endfunction

    task automatic send_item(input upload_item_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, it.time_now, it.payload_length, it.seg_bytes,
                          it.upload_bytes, it.block_index, it.want_ack, it.frame_short};
        s_axis_tuser  <= it.tick;
        s_axis_tlast  <= it.is_last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        tracker.note_input(it);
        items_sent++;
    endtask

    task automatic send_tick(input int unsigned delta);
        now_ms += delta;
        send_item(tick_item(now_ms));
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
        logic [31:0] want;
        want = (addr[2] == REG_TIMEOUT) ? {16'b0, value[15:0]} : value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        tracker.set_register(addr, value);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== want) begin
            tracker.flag_error($sformatf("register at %0d: expected %0h, read %0h",
                                         addr, want, prdata));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending_replies.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_noise();
        upload_item_t it;
        int           r;
        it = random_item();
        it.time_now = now_ms;
        r = $urandom_range(0, 99);
        if (r < 20) begin
            it.block_index = CANCEL_INDEX;
        end else if (r < 30) begin
            it.upload_bytes = '0;
        end else if (r < 50) begin
            it.time_now = $urandom();
        end
        send_item(it);
    endtask

    task automatic run_session();
        int unsigned     blen, nseg, cap, idx, a, b;
        int unsigned     order[$];
        longint unsigned total64;
        logic [31:0]     total;
        logic [15:0]     plen;
        bit              last;
        int              r;
        upload_item_t    it;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            blen = $urandom_range(1, 300);
        end else if (r < 90) begin
            blen = $urandom_range(301, 65535);
        end else begin
            blen = $urandom_range(0, 1) ? 1 : 65535;
        end
        r = $urandom_range(0, 99);
        if (r < 88) begin
            nseg = $urandom_range(1, 20);
        end else if (r < 97) begin
            nseg = $urandom_range(21, 300);
        end else begin
            nseg = $urandom_range(4090, 4100);
        end
        total64 = nseg - 1;
        total64 = total64 * blen + $urandom_range(1, blen);
        total = (total64 > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : total64[31:0];
        if (nseg <= 40) begin
            for (int unsigned i = 0; i < nseg; i++) order.push_back(i);
        end else begin
            repeat (12) order.push_back($urandom_range(0, nseg - 1));
            order.push_back(nseg - 1);
        end
        if (order.size() > 1 && $urandom_range(0, 99) < 20) begin
            a = $urandom_range(0, order.size() - 1);
            b = $urandom_range(0, order.size() - 1);
            idx = order[a];
            order[a] = order[b];
            order[b] = idx;
        end
        if (order.size() > 1 && $urandom_range(0, 99) < 10) begin
            order.delete($urandom_range(0, order.size() - 2));
        end
        if ($urandom_range(0, 99) < 10) begin
            a = $urandom_range(0, order.size() - 1);
            order.insert(a, order[a]);
        end
        if ($urandom_range(0, 99) < 5) begin
            order.insert($urandom_range(0, order.size() - 1), nseg + $urandom_range(0, 2));
        end
        cap = (blen + 50 > 65535) ? 65535 : blen + 50;
        foreach (order[k]) begin
            if ($urandom_range(0, 9) == 0) begin
                send_tick($urandom_range(0, 99) < 15 ? tracker.timeout_limit + 1 :
                          $urandom_range(0, tracker.timeout_limit));
            end
            idx  = order[k];
            last = (idx == nseg - 1);
            if ($urandom_range(0, 99) < 5) last = !last;
            r = $urandom_range(0, 99);
            if (r < 88) begin
                plen = $urandom_range(0, blen);
            end else if (r < 94) begin
                plen = cap;
            end else begin
                plen = (cap < 65535) ? $urandom_range(cap + 1, 65535) : 16'hFFFF;
            end
            now_ms += $urandom_range(0, 50);
            it = seg_item(idx, total, blen, plen, $urandom_range(0, 99) < 60, last, now_ms);
            if (k > 0 && $urandom_range(0, 99) < 15) begin
                it.upload_bytes = $urandom_range(1, 32'hFFFF_FFFF);
                it.seg_bytes    = $urandom_range(1, 65535);
            end
            send_item(it);
        end
        if ($urandom_range(0, 99) < 30) begin
            send_item(seg_item(nseg - 1, total, blen, 0, 1'b1, 1'b1, now_ms));
        end
        r = $urandom_range(0, 99);
        if (r < 45) begin
            now_ms += $urandom_range(0, 20);
            if ($urandom_range(0, 1)) begin
                send_item(seg_item(CANCEL_INDEX, total, blen, 0, 1'b1, 1'b0, now_ms));
            end else begin
                send_item(seg_item($urandom(), '0, $urandom_range(0, 65535), 0, 1'b0,
                                   1'b0, now_ms));
            end
        end else if (r < 65) begin
            send_tick(tracker.timeout_limit + $urandom_range(1, 500));
        end
    endtask

    task automatic run_phase(input logic [15:0] tmo, input logic [31:0] max_bytes,
                             input int unsigned count, input bit idle_on);
        int unsigned stop_at;
        drain();
        write_reg({REG_TIMEOUT, 2'b00}, {16'b0, tmo});
        write_reg({REG_MAX_TOTAL, 2'b00}, max_bytes);
        @(posedge i_clk);
        gaps_on   = idle_on;
        stalls_on = idle_on;
        stop_at   = items_sent + count;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 99) < 85) begin
                run_session();
            end else begin
                send_noise();
            end
        end
    endtask

    initial begin
        upload_item_t it;
        tracker = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(tick_item(32'd1000));
        it = seg_item(0, 100, 40, 40, 1'b1, 1'b0, 32'd1000);
        it.frame_short = 1'b1;
        send_item(it);
        send_item(seg_item(CANCEL_INDEX, 100, 40, 0, 1'b1, 1'b0, 32'd1001));
        send_item(seg_item(3, 0, 40, 0, 1'b1, 1'b0, 32'd1002));
        send_item(seg_item(0, 100, 0, 0, 1'b1, 1'b0, 32'd1003));
        send_item(seg_item(0, MAX_TOTAL_RST + 1, 1000, 0, 1'b1, 1'b0, 32'd1004));
        send_item(seg_item(0, 4097, 1, 0, 1'b1, 1'b0, 32'd1005));
        send_item(seg_item(0, 4096, 1, 0, 1'b1, 1'b0, 32'd1006));
        send_item(seg_item(4095, 4096, 1, 51, 1'b1, 1'b1, 32'd1007));
        send_item(seg_item(4096, 4096, 1, 1, 1'b1, 1'b0, 32'd1008));
        send_item(seg_item(0, 100, 40, 40, 1'b1, 1'b0, 32'd1010));
        send_item(seg_item(0, 100, 40, 90, 1'b1, 1'b0, 32'd1011));
        send_item(seg_item(2, 100, 40, 20, 1'b1, 1'b0, 32'd1012));
        send_item(seg_item(2, 100, 40, 20, 1'b1, 1'b1, 32'd1013));
        send_item(seg_item(1, 100, 40, 40, 1'b0, 1'b0, 32'd1014));
        send_item(seg_item(2, 100, 40, 20, 1'b1, 1'b1, 32'd1015));
        send_item(seg_item(2, 100, 40, 20, 1'b1, 1'b1, 32'd1016));
        send_item(tick_item(32'd200000));
        send_item(seg_item(1, 100, 40, 91, 1'b1, 1'b0, 32'd1017));
        send_item(seg_item(0, MAX_TOTAL_RST, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 32'hFFFF_FFFF));
        send_item(tick_item(32'hFFFF_FFFF));
        send_item(seg_item(1, MAX_TOTAL_RST, 16'hFFFF, 7, 1'b0, 1'b0, 32'd100));
        send_item(tick_item(32'd5100));
        send_item(tick_item(32'd5101));
        send_item(tick_item(32'd9000));

        run_phase(16'd1, 32'hFFFF_FFFF, 250, 1'b1);
        run_phase(16'hFFFF, 32'd1, 60, 1'b1);
        run_phase(16'd300, 32'd50000, 300, 1'b0);
        run_phase($urandom_range(1, 65535), $urandom_range(100000, 32'hFFFF_FFFF), 300, 1'b1);
        run_phase(TIMEOUT_RST, MAX_TOTAL_RST, 300, 1'b1);
        run_phase(16'hFFFF, 32'hFFFF_FFFF, 200, 1'b1);

        drain();
        if (tracker.mismatches == 0 && tracker.pending_replies.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### segmented_upload_receiver.f
rtl/core/sur_pkg.sv
rtl/core/sur_div.sv
rtl/core/segmented_upload_receiver.sv
verif/tb_top.sv
